### design/erfb_pkg.sv
// ----------------------------------------------------------------------------
// erfb_pkg: shared constants and helpers for the field-to-body rotator
// Holds the CORDIC arctangent table, fixed-point constants and the word types.
// ----------------------------------------------------------------------------
package erfb_pkg;

   localparam int TRIG_BITS_DEF = 16;
   localparam int CORDIC_N      = 30;
   localparam int ZW            = 34;   // angle accumulator, Q30 plus headroom
   localparam int XW            = 33;   // CORDIC x/y datapath width
   localparam int ANG_W         = 16;
   localparam int FLD_W         = 18;
   localparam int OUT_W         = 19;

   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic [31:0] t;
      unique case (i)
         0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
         3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
         6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
         9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
        12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
        15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
        18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
        21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
        24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
        27: t = 32'h00000007; 28: t = 32'h00000003; 29: t = 32'h00000001;
        default: t = 32'h0;
      endcase
      return signed'({2'b00, t});
   endfunction

   // one angle's CORDIC state as it moves down the chain
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 flip;
   } rot_type;

endpackage

### design/erfb_cell.sv
// ----------------------------------------------------------------------------
// erfb_cell: one CORDIC micro-rotation for three angles
// Rotates by atan(2^-STEP) toward zero residual and registers the result.
// ----------------------------------------------------------------------------
module erfb_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  erfb_pkg::rot_type      rot_in [3],
   output erfb_pkg::rot_type      rot_out [3]
);

   erfb_pkg::rot_type rot_ff [3];
   erfb_pkg::rot_type rot_in_n [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rot_in_n[k].flip = rot_in[k].flip;
         if (!rot_in[k].z[erfb_pkg::ZW-1]) begin
            rot_in_n[k].x = rot_in[k].x - (rot_in[k].y >>> STEP);
            rot_in_n[k].y = rot_in[k].y + (rot_in[k].x >>> STEP);
            rot_in_n[k].z = rot_in[k].z - erfb_pkg::atan_q30(STEP);
         end else begin
            rot_in_n[k].x = rot_in[k].x + (rot_in[k].y >>> STEP);
            rot_in_n[k].y = rot_in[k].y - (rot_in[k].x >>> STEP);
            rot_in_n[k].z = rot_in[k].z + erfb_pkg::atan_q30(STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) rot_ff <= rot_in_n;
   end

   assign rot_out = rot_ff;

endmodule

### design/erfb_matrix.sv
// ----------------------------------------------------------------------------
// erfb_matrix: trig rounding, rotation matrix and transposed product
// Five registered stages: trig, first products, entries, field products, sum.
// ----------------------------------------------------------------------------
module erfb_matrix #(
   parameter int TRIG_BITS = erfb_pkg::TRIG_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                enable,
   input  erfb_pkg::rot_type                   rot_in [3],
   input  logic signed [erfb_pkg::FLD_W-1:0]   fld_in [3],
   output logic signed [erfb_pkg::OUT_W-1:0]   body_out [3]
);

   localparam int TW = TRIG_BITS + 2;           // trig value, |v| <= 2^TRIG_BITS
   localparam int PW = 2 * TW;
   localparam int EW = TRIG_BITS + 4;           // matrix entry
   localparam int MW = EW + erfb_pkg::FLD_W;    // entry times field
   localparam int AW = MW + 2;
   localparam int SH = 30 - TRIG_BITS;

   function automatic logic signed [TW-1:0] trig_rnd(input logic signed [erfb_pkg::XW-1:0] v,
                                                      input logic flip);
      logic signed [erfb_pkg::XW:0] a;
      logic signed [erfb_pkg::XW:0] r;
      logic signed [erfb_pkg::XW:0] one;
      a   = flip ? -(erfb_pkg::XW+1)'(v) : (erfb_pkg::XW+1)'(v);
      r   = (a + ((erfb_pkg::XW+1)'(1) <<< (SH - 1))) >>> SH;
      one = (erfb_pkg::XW+1)'(1) <<< TRIG_BITS;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return TW'(r);
   endfunction

   function automatic logic signed [TW-1:0] fmul(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
      logic signed [PW-1:0] p;
      p = (PW'(a) * PW'(b) + (PW'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
      return TW'(p);
   endfunction

   // stage 1: s/c for roll(0), pitch(1), yaw(2)
   logic signed [TW-1:0] s_ff [3], c_ff [3];
   logic signed [erfb_pkg::FLD_W-1:0] f1_ff [3], f2_ff [3], f3_ff [3];
   // stage 2: simple products
   logic signed [TW-1:0] cycp_ff, sycr_ff, srsy_ff, sypc_ff, cycr_ff, cysr_ff;
   logic signed [TW-1:0] spsr_ff, spcr_ff, cpsr_ff, cpcr_ff, sp2_ff, cy2_ff, sy2_ff;
   // stage 3: entries
   logic signed [EW-1:0] r_ff [9];
   // stage 4: field products
   logic signed [MW-1:0] m_ff [9];
   logic signed [erfb_pkg::OUT_W-1:0] o_ff [3];

   logic signed [AW-1:0] acc [3];
   logic signed [AW-1:0] rv [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc[k] = AW'(m_ff[k]) + AW'(m_ff[k+3]) + AW'(m_ff[k+6]);
         rv[k]  = (acc[k] + (AW'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            s_ff[k] <= trig_rnd(rot_in[k].y, rot_in[k].flip);
            c_ff[k] <= trig_rnd(rot_in[k].x, rot_in[k].flip);
         end
         f1_ff <= fld_in;
         cycp_ff <= fmul(c_ff[2], c_ff[1]);
         sycr_ff <= fmul(s_ff[2], c_ff[0]);
         srsy_ff <= fmul(s_ff[0], s_ff[2]);
         sypc_ff <= fmul(s_ff[2], c_ff[1]);
         cycr_ff <= fmul(c_ff[2], c_ff[0]);
         cysr_ff <= fmul(c_ff[2], s_ff[0]);
         spsr_ff <= fmul(s_ff[1], s_ff[0]);
         spcr_ff <= fmul(s_ff[1], c_ff[0]);
         cpsr_ff <= fmul(c_ff[1], s_ff[0]);
         cpcr_ff <= fmul(c_ff[1], c_ff[0]);
         sp2_ff  <= s_ff[1];
         cy2_ff  <= c_ff[2];
         sy2_ff  <= s_ff[2];
         f2_ff   <= f1_ff;
         // order: r11 r12 r13 r21 r22 r23 r31 r32 r33
         r_ff[0] <= EW'(cycp_ff);
         r_ff[1] <= EW'(fmul(cy2_ff, spsr_ff)) - EW'(sycr_ff);
         r_ff[2] <= EW'(srsy_ff) + EW'(fmul(cy2_ff, spcr_ff));
         r_ff[3] <= EW'(sypc_ff);
         r_ff[4] <= EW'(cycr_ff) + EW'(fmul(sy2_ff, spsr_ff));
         r_ff[5] <= EW'(fmul(sy2_ff, spcr_ff)) - EW'(cysr_ff);
         r_ff[6] <= -EW'(sp2_ff);
         r_ff[7] <= EW'(cpsr_ff);
         r_ff[8] <= EW'(cpcr_ff);
         f3_ff   <= f2_ff;
         // transposed product: column k of the matrix against the field
         for (int k = 0; k < 3; k++) begin
            m_ff[k]   <= MW'(r_ff[k])   * MW'(f3_ff[0]);
            m_ff[k+3] <= MW'(r_ff[k+3]) * MW'(f3_ff[1]);
            m_ff[k+6] <= MW'(r_ff[k+6]) * MW'(f3_ff[2]);
         end
         for (int k = 0; k < 3; k++) begin
            if (rv[k] > AW'(262143))       o_ff[k] <= 19'sh3FFFF;
            else if (rv[k] < -AW'(262144)) o_ff[k] <= 19'sh40000;
            else                           o_ff[k] <= erfb_pkg::OUT_W'(rv[k]);
         end
      end
   end

   assign body_out = o_ff;

endmodule

### design/euler_rotate_field_to_body.sv
// ----------------------------------------------------------------------------
// euler_rotate_field_to_body: reference field into the body frame
// Z-Y-X rotation matrix from CORDIC sine/cosine, transposed times the field.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req_    | in  | tdata: roll, pitch, yaw, ref x, y, z
//  rsp_    | out | tdata: body x, y, z
// One word per cycle while rsp_ does not stall; 1 input register + 30 CORDIC cells + 5 matrix stages.
// The pipeline advances as a whole whenever its last stage is free or taken.
// Synchronous reset clears only the valid chain.
// A stalled rsp_ freezes every stage; req_tready follows rsp_ side space.
module euler_rotate_field_to_body #(
   parameter int TRIG_BITS = erfb_pkg::TRIG_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // roll[15:0] pitch[31:16] yaw[47:32] x[65:48] y[83:66] z[101:84]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata    // x[18:0] y[37:19] z[56:38]
);

   localparam int N = erfb_pkg::CORDIC_N;
   localparam int LAT = N + 6;

   logic [LAT-1:0] vld_ff, vld_in;
   logic enable;
   assign enable = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = enable;

   always_comb begin
      vld_in = vld_ff;
      if (enable) vld_in = {vld_ff[LAT-2:0], req_tvalid};
   end
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   // input register with quadrant reduction
   erfb_pkg::rot_type rot0_ff [3];
   logic signed [erfb_pkg::FLD_W-1:0] fld_ff [3];
   erfb_pkg::rot_type chain [N+1][3];
   logic signed [erfb_pkg::ZW-1:0] zq [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         zq[k] = erfb_pkg::ZW'($signed(req_tdata[16*k +: 16])) <<< 17;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            rot0_ff[k].x <= erfb_pkg::GAIN_Q30;
            rot0_ff[k].y <= '0;
            if (zq[k] > erfb_pkg::HALF_PI_Q30) begin
               rot0_ff[k].z <= zq[k] - erfb_pkg::PI_Q30; rot0_ff[k].flip <= 1'b1;
            end else if (zq[k] < -erfb_pkg::HALF_PI_Q30) begin
               rot0_ff[k].z <= zq[k] + erfb_pkg::PI_Q30; rot0_ff[k].flip <= 1'b1;
            end else begin
               rot0_ff[k].z <= zq[k]; rot0_ff[k].flip <= 1'b0;
            end
         end
         fld_ff[0] <= $signed(req_tdata[65:48]);
         fld_ff[1] <= $signed(req_tdata[83:66]);
         fld_ff[2] <= $signed(req_tdata[101:84]);
      end
   end
   assign chain[0] = rot0_ff;

   // field words ride alongside the CORDIC chain
   logic signed [erfb_pkg::FLD_W-1:0] fdel_ff [N][3];
   always_ff @(posedge clock) begin
      if (enable) begin
         fdel_ff[0] <= fld_ff;
         for (int i = 1; i < N; i++) fdel_ff[i] <= fdel_ff[i-1];
      end
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         erfb_cell #(.STEP(g)) u_cell (
            .clock(clock), .enable(enable), .rot_in(chain[g]), .rot_out(chain[g+1]));
      end
   endgenerate

   logic signed [erfb_pkg::OUT_W-1:0] body [3];
   erfb_matrix #(.TRIG_BITS(TRIG_BITS)) u_matrix (
      .clock(clock), .enable(enable), .rot_in(chain[N]),
      .fld_in(fdel_ff[N-1]), .body_out(body));

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {7'd0, body[2], body[1], body[0]};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("not ready while output empty");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0]) else $error("accepted word lost");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for euler_rotate_field_to_body
// Drives attitude/field words through the stream port, predicts each body
// field vector with an integer CORDIC rotation model, or takes a row's typed values, and compares per field.
// ----------------------------------------------------------------------------
module tb;

   localparam int TB_TRIG  = erfb_pkg::TRIG_BITS_DEF;
   localparam int N_RAND   = 1530;
   localparam int LATENCY  = 36;
   localparam int STALL_LEN = 300;
   localparam int WDOG_MAX = 4000;

   typedef struct {
      logic signed [15:0] roll, pitch, yaw;
      logic signed [17:0] fx, fy, fz;
      bit                 known;
      logic signed [18:0] ex, ey, ez;
   } attitude_row_type;

   typedef struct packed {
      logic [18:0] bx, by, bz;
   } body_vec_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;    // roll, pitch, yaw, ref x, y, z
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;         // body x, y, z

   body_vec_type body_q[$];
   int           n_errors = 0;
   int           snd_idle = 25, rcv_idle = 77;
   bit           hold_req = 1'b0;
   int           quiet = 0;

   const longint arctan_q30[30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};

   euler_rotate_field_to_body uut (.*);

   always #1 clock = ~clock;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint fxmul(longint a, longint b);
      return round_shift(a * b, TB_TRIG);
   endfunction

   function automatic longint trig_sat(longint v);
      longint r, one;
      r = round_shift(v, 30 - TB_TRIG);
      one = longint'(1) <<< TB_TRIG;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r;
   endfunction

   task automatic sin_cos_q(input logic signed [15:0] ang, output longint s, output longint c);
      longint z, x, y, nx;
      bit     flip;
      z = longint'(ang) * 131072;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 1686629713) begin
         z -= 64'sd3373259426;
         flip = 1'b1;
      end else if (z < -1686629713) begin
         z += 64'sd3373259426;
         flip = 1'b1;
      end
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= arctan_q30[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += arctan_q30[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = trig_sat(x);
      s = trig_sat(y);
   endtask

   function automatic logic [18:0] to_nt(longint acc);
      longint v;
      v = round_shift(acc, TB_TRIG);
      if (v > 262143) v = 262143;
      if (v < -262144) v = -262144;
      return v[18:0];
   endfunction

   task automatic rotate_to_body(input attitude_row_type a, output body_vec_type b);
      longint sr, cr, sp, cp, sy, cy, fx, fy, fz;
      longint r11, r12, r13, r21, r22, r23, r31, r32, r33;
      sin_cos_q(a.roll, sr, cr);
      sin_cos_q(a.pitch, sp, cp);
      sin_cos_q(a.yaw, sy, cy);
      fx = a.fx; fy = a.fy; fz = a.fz;
      r11 = fxmul(cy, cp);
      r12 = -fxmul(sy, cr) + fxmul(cy, fxmul(sp, sr));
      r13 = fxmul(sr, sy) + fxmul(cy, fxmul(sp, cr));
      r21 = fxmul(sy, cp);
      r22 = fxmul(cy, cr) + fxmul(sy, fxmul(sr, sp));
      r23 = -fxmul(cy, sr) + fxmul(sy, fxmul(sp, cr));
      r31 = -sp;
      r32 = fxmul(cp, sr);
      r33 = fxmul(cp, cr);
      b.bx = to_nt(r11 * fx + r21 * fy + r31 * fz);
      b.by = to_nt(r12 * fx + r22 * fy + r32 * fz);
      b.bz = to_nt(r13 * fx + r23 * fy + r33 * fz);
   endtask

   task automatic report_mismatch(input string what, input logic [18:0] got, input logic [18:0] exp_v);
      $display("mismatch %s: got %0d expected %0d at %0t", what,
               $signed(got), $signed(exp_v), $realtime);
      n_errors++;
   endtask

   function automatic attitude_row_type row(int r, int p, int y, int x, int fy, int fz,
                                            bit known = 0, int ex = 0, int ey = 0, int ez = 0);
      attitude_row_type a;
      a.roll = 16'(r); a.pitch = 16'(p); a.yaw = 16'(y);
      a.fx = 18'(x); a.fy = 18'(fy); a.fz = 18'(fz);
      a.known = known; a.ex = 19'(ex); a.ey = 19'(ey); a.ez = 19'(ez);
      return a;
   endfunction

   function automatic int rand_angle();
      int k;
      k = $urandom_range(99);
      if (k < 8) return $signed(16'($urandom));
      if (k < 16) return ($urandom_range(1) ? 12868 : -12868) + $urandom_range(8) - 4;
      return int'($urandom_range(51472)) - 25736;
   endfunction

   function automatic int rand_field();
      if ($urandom_range(9) == 0) return $signed(18'($urandom));
      return int'($urandom_range(200000)) - 100000;
   endfunction

   // receiver side, with one long hold-off so the pipe fills
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            repeat (STALL_LEN) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= ($urandom_range(99) >= rcv_idle);
         @(posedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         body_vec_type got, exp_v;
         got = rsp_tdata[56:0];
         if (body_q.size() == 0) begin
            $display("unexpected result word at %0t", $realtime);
            n_errors++;
         end else begin
            exp_v = body_q.pop_front();
            if (got.bz != exp_v.bz) report_mismatch("body_x", got.bz, exp_v.bz);
            if (got.by != exp_v.by) report_mismatch("body_y", got.by, exp_v.by);
            if (got.bx != exp_v.bx) report_mismatch("body_z", got.bx, exp_v.bx);
         end
      end
   end

   // watchdog on words moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WDOG_MAX) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_word(input attitude_row_type a);
      body_vec_type b;
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, a.fz, a.fy, a.fx, a.yaw, a.pitch, a.roll};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rotate_to_body(a, b);
      // body_vec_type packs x in the top bits, so the struct order is z, y, x
      if (a.known) begin
         body_q.push_back('{bx: a.ez, by: a.ey, bz: a.ex});
         if (b.bx != a.ex || b.by != a.ey || b.bz != a.ez)
            $display("note: predictor disagrees with typed row");
      end else begin
         body_q.push_back('{bx: b.bz, by: b.by, bz: b.bx});
      end
   endtask

   initial begin
      attitude_row_type drows[$];
      drows = '{
         row(0, 0, 0, 100000, -100000, 5, 1, 100000, -100000, 5),
         row(0, 0, 0, 131071, -131072, 0, 1, 131071, -131072, 0),
         row(0, 0, 0, -1, 1, -131072, 1, -1, 1, -131072),
         row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
         row(25736, 0, 0, 100000, 50000, -30000),
         row(-25736, 0, 0, 100000, 50000, -30000),
         row(0, 25736, 0, -100000, 100000, 100000),
         row(0, -25736, 0, 100000, -100000, -100000),
         row(0, 0, 25736, 12345, -54321, 99999),
         row(0, 0, -25736, 12345, -54321, 99999),
         row(12868, 0, 0, 40000, 40000, 40000),
         row(0, 12868, 0, 40000, 40000, 40000),
         row(0, 0, -12868, 40000, 40000, 40000),
         row(12869, -12869, 12867, 70000, -20000, 10000),
         row(32767, -32768, 32767, 131071, 131071, 131071),
         row(-32768, 32767, -32768, -131072, -131072, -131072),
         row(-1, 1, -1, 100000, 100000, 100000),
         row(25736, 25736, 25736, -100000, -100000, -100000),
         row(-25736, -25736, -25736, 100000, 100000, 100000),
         row(8192, -4096, 16384, 22000, -5000, 43000)};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (drows[i]) send_word(drows[i]);
      for (int n = 0; n < N_RAND; n++) begin
         if (n == N_RAND / 3) begin
            snd_idle = 77; rcv_idle = 25;
         end else if (n == 2 * N_RAND / 3) begin
            snd_idle = 0; rcv_idle = 0; hold_req = 1'b1;
         end
         send_word(row(rand_angle(), rand_angle(), rand_angle(),
                       rand_field(), rand_field(), rand_field()));
      end
      req_tvalid <= 1'b0;
      while (body_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (n_errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
design/erfb_pkg.sv
design/erfb_cell.sv
design/erfb_matrix.sv
design/euler_rotate_field_to_body.sv
verif/tb.sv
